[src/spem_pkg.sv]
// ----------------------------------------------------------------------------
// spem_pkg
// Shared types and constants of the 3x3 edge gradient magnitude block.
// ----------------------------------------------------------------------------
package spem_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int PIX_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IMG_W_BITS    = 12;
    localparam int IMG_H_BITS    = 16;
    localparam int SUM_W         = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic MODE_SOBEL = 1'b0;

    localparam logic [IMG_W_BITS-1:0] RST_WIDTH  = 12'd640;
    localparam logic [IMG_H_BITS-1:0] RST_HEIGHT = 16'd480;

    localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;
    localparam logic [SUM_W-1:0] SAT_LEVEL = 21'd65025;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic is_drain;
        logic row0;
        logic first_col;
        logic emit_a;
        logic emit_b;
        logic last;
    } t_cmd_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SUM,
        ST_ROOT,
        ST_SEND
    } t_back_state;

endpackage

[src/spem_pix_if.sv]
// ----------------------------------------------------------------------------
// spem_pix_if
// Input pixel channel: pixel or drain tick with valid/ready.
// ----------------------------------------------------------------------------
interface spem_pix_if import spem_pkg::*; ();
    logic valid;
    logic ready;
    logic kind;
    t_pix pixel_value;

    modport source (output valid, kind, pixel_value, input ready);
    modport sink (input valid, kind, pixel_value, output ready);
endinterface

[src/spem_mag_if.sv]
// ----------------------------------------------------------------------------
// spem_mag_if
// Output channel: gradient magnitude with line and frame markers.
// ----------------------------------------------------------------------------
interface spem_mag_if import spem_pkg::*; ();
    logic valid;
    logic ready;
    t_pix magnitude;
    logic end_of_line;
    logic end_of_frame;
    logic last_in_run;

    modport source (output valid, magnitude, end_of_line, end_of_frame, last_in_run,
                    input ready);
    modport sink (input valid, magnitude, end_of_line, end_of_frame, last_in_run,
                  output ready);
endinterface

[src/spem_cfg_if.sv]
// ----------------------------------------------------------------------------
// spem_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spem_cfg_if import spem_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/sobel_prewitt_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_prewitt_edge_magnitude
// 3x3 Sobel/Prewitt gradient magnitude over a raster-order grey stream.
// ----------------------------------------------------------------------------
// i_pix carries raster pixels (kind 0) and, after the last pixel of a frame,
// one drain tick (kind 1) per column that flushes the last row. o_mag gives
// one saturated magnitude per image pixel, lagging one row and one column,
// with end_of_line, end_of_frame and last_in_run markers. i_cfg writes
// kernel_mode, image_width and image_height; the user is to write them
// only while the block is idle, as the block does not enforce it. The
// front tracks positions and queues commands in a two-entry queue; the
// back reads the line stores, updates the window and computes the root.
// A pixel passes pop, store read and window load, then for each result a
// sum, eight square root steps and a send; a saturated sum leaves the root
// after one step. A drain tick passes its pop and three store reads, then
// its result. The square root sequencer sets the rate. Results pass through
// an output register; while the receiver stalls, the back holds, the queue
// fills up and the front stops accepting items.
// Reset clears positions, the queue and the output valid; line stores are
// not cleared, and values read from them before they are written go unused.
// ----------------------------------------------------------------------------
module sobel_prewitt_edge_magnitude import spem_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spem_pix_if.sink     i_pix,
    spem_mag_if.source   o_mag,
    spem_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = $bits(t_cmd_flags) + PIX_W + 3 * AW;

    logic                  r_mode;
    logic [IMG_W_BITS-1:0] r_width;
    logic [IMG_H_BITS-1:0] r_height;

    logic          push, pop, full, empty;
    t_cmd_flags    f_flags, b_flags;
    t_pix          f_pix, b_pix;
    logic [AW-1:0] f_a0, f_a1, f_a2, b_a0, b_a1, b_a2;
    logic [DW-1:0] q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SOBEL;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KERNEL_MODE:  r_mode   <= i_cfg.data[0];
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg.data[IMG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    spem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_pix.valid),
        .i_kind         (i_pix.kind),
        .i_pix          (i_pix.pixel_value),
        .o_ready        (i_pix.ready),
        .i_image_width  (r_width),
        .i_image_height (r_height),
        .i_full         (full),
        .o_push         (push),
        .o_flags        (f_flags),
        .o_pix          (f_pix),
        .o_addr0        (f_a0),
        .o_addr1        (f_a1),
        .o_addr2        (f_a2)
    );

    spem_queue #(.DW(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_pix, f_a0, f_a1, f_a2}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {b_flags, b_pix, b_a0, b_a1, b_a2} = q_out;

    spem_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_mode),
        .i_empty        (empty),
        .i_flags        (b_flags),
        .i_pix          (b_pix),
        .i_addr0        (b_a0),
        .i_addr1        (b_a1),
        .i_addr2        (b_a2),
        .o_pop          (pop),
        .o_valid        (o_mag.valid),
        .i_ready        (o_mag.ready),
        .o_magnitude    (o_mag.magnitude),
        .o_end_of_line  (o_mag.end_of_line),
        .o_end_of_frame (o_mag.end_of_frame),
        .o_last_in_run  (o_mag.last_in_run)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("command popped from empty queue");

    a_eof_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mag.valid && o_mag.end_of_frame) |-> (o_mag.end_of_line && o_mag.last_in_run))
        else $error("end of frame without end of line and last in run");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_mag.valid) else $error("output valid right after reset");

endmodule

[src/spem_front.sv]
// ----------------------------------------------------------------------------
// spem_front
// Accepts items, tracks raster and drain positions, issues commands.
// ----------------------------------------------------------------------------
module spem_front import spem_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_kind,
    input  t_pix                  i_pix,
    output logic                  o_ready,
    input  logic [IMG_W_BITS-1:0] i_image_width,
    input  logic [IMG_H_BITS-1:0] i_image_height,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd_flags            o_flags,
    output t_pix                  o_pix,
    output logic [AW-1:0]         o_addr0,
    output logic [AW-1:0]         o_addr1,
    output logic [AW-1:0]         o_addr2
);

    logic [AW-1:0]         r_col, n_col;
    logic [IMG_H_BITS-1:0] r_row, n_row;
    logic [AW-1:0]         r_drain, n_drain;
    logic                  r_await, n_await;

    logic [AW:0]           w_eff;
    logic [AW-1:0]         w_last;
    logic [IMG_H_BITS-1:0] h_last;
    logic                  accept;

    always_comb begin
        if (i_image_width == '0) begin
            w_eff = (AW+1)'(1);
        end else if (32'(i_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = (AW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (AW+1)'(i_image_width);
        end
        w_last = AW'(w_eff - (AW+1)'(1));
        h_last = (i_image_height == '0) ? '0 : i_image_height - 16'd1;
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_pix   = i_pix;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        n_await = r_await;
        o_push  = 1'b0;
        o_flags = '0;
        o_addr0 = r_col;
        o_addr1 = r_col;
        o_addr2 = r_col;
        if (accept && i_kind == KIND_PIXEL && !r_await) begin
            o_push            = 1'b1;
            o_flags.row0      = (r_row == '0);
            o_flags.first_col = (r_col == '0);
            o_flags.emit_a    = (r_row != '0) && (r_col != '0);
            o_flags.emit_b    = (r_row != '0) && (r_col >= w_last);
            if (r_col >= w_last) begin
                n_col = '0;
                if (r_row >= h_last) begin
                    n_row   = '0;
                    n_drain = '0;
                    n_await = 1'b1;
                end else begin
                    n_row = r_row + 16'd1;
                end
            end else begin
                n_col = r_col + AW'(1);
            end
        end else if (accept && i_kind == KIND_DRAIN && r_await) begin
            o_push           = 1'b1;
            o_flags.is_drain = 1'b1;
            o_flags.last     = (r_drain >= w_last);
            o_addr0          = (r_drain == '0) ? '0 : r_drain - AW'(1);
            o_addr1          = r_drain;
            o_addr2          = (r_drain < w_last) ? r_drain + AW'(1) : r_drain;
            if (r_drain >= w_last) begin
                n_drain = '0;
                n_await = 1'b0;
            end else begin
                n_drain = r_drain + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
            r_await <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
            r_await <= n_await;
        end
    end

endmodule

[src/spem_queue.sv]
// ----------------------------------------------------------------------------
// spem_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module spem_queue import spem_pkg::*; #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[src/spem_back.sv]
// ----------------------------------------------------------------------------
// spem_back
// Line stores, 3x3 window, gradient and bit-serial square root sequencer.
// ----------------------------------------------------------------------------
module spem_back import spem_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_mode,
    input  logic       i_empty,
    input  t_cmd_flags i_flags,
    input  t_pix       i_pix,
    input  logic [AW-1:0] i_addr0,
    input  logic [AW-1:0] i_addr1,
    input  logic [AW-1:0] i_addr2,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_pix       o_magnitude,
    output logic       o_end_of_line,
    output logic       o_end_of_frame,
    output logic       o_last_in_run
);

    t_back_state r_state, n_state;

    t_pix upper_mem [MAX_WIDTH];
    t_pix lower_mem [MAX_WIDTH];
    t_pix r_up_rd, r_lo_rd;

    t_cmd_flags    r_flags;
    t_pix          r_pix;
    logic [AW-1:0] r_addr0, r_addr1, r_addr2;
    logic [1:0]    r_step;
    logic          r_phase;
    t_pix          r_win [3][3];
    logic [SUM_W-1:0] r_sum;
    t_pix          r_root;
    logic [2:0]    r_bit;

    logic          r_out_valid;
    t_pix          r_out_mag;
    logic          r_out_eol, r_out_eof, r_out_lir;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    t_pix          v [3];
    t_pix          g [3][3];
    logic [9:0]    xl, xr, yt, yb, ax, ay;
    logic signed [10:0] gx, gy;
    logic [19:0]   ax2, ay2;
    t_pix          trial;
    logic [15:0]   tsq;
    logic          send_ok;

    always_comb begin
        case (r_step)
            2'd0:    rd_addr = r_addr0;
            2'd1:    rd_addr = r_addr1;
            default: rd_addr = r_addr2;
        endcase
    end

    assign mem_we = (r_state == ST_LOAD) && !r_flags.is_drain;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            upper_mem[r_addr0] <= r_flags.row0 ? r_pix : r_lo_rd;
            lower_mem[r_addr0] <= r_pix;
        end
        r_up_rd <= upper_mem[rd_addr];
        r_lo_rd <= lower_mem[rd_addr];
    end

    // new window column for a pixel; first row stands in for the rows above
    always_comb begin
        v[0] = r_flags.row0 ? r_pix : r_up_rd;
        v[1] = r_flags.row0 ? r_pix : r_lo_rd;
        v[2] = r_pix;
    end

    // second result at row end sees the right column replicated
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_phase && !r_flags.is_drain) begin
                g[r][0] = r_win[r][1];
                g[r][1] = r_win[r][2];
                g[r][2] = r_win[r][2];
            end else begin
                g[r][0] = r_win[r][0];
                g[r][1] = r_win[r][1];
                g[r][2] = r_win[r][2];
            end
        end
    end

    always_comb begin
        if (i_mode == MODE_SOBEL) begin
            xl = 10'(g[0][0]) + {1'b0, g[1][0], 1'b0} + 10'(g[2][0]);
            xr = 10'(g[0][2]) + {1'b0, g[1][2], 1'b0} + 10'(g[2][2]);
            yt = 10'(g[0][0]) + {1'b0, g[0][1], 1'b0} + 10'(g[0][2]);
            yb = 10'(g[2][0]) + {1'b0, g[2][1], 1'b0} + 10'(g[2][2]);
        end else begin
            xl = 10'(g[0][0]) + 10'(g[1][0]) + 10'(g[2][0]);
            xr = 10'(g[0][2]) + 10'(g[1][2]) + 10'(g[2][2]);
            yt = 10'(g[0][0]) + 10'(g[0][1]) + 10'(g[0][2]);
            yb = 10'(g[2][0]) + 10'(g[2][1]) + 10'(g[2][2]);
        end
        gx  = $signed({1'b0, xl}) - $signed({1'b0, xr});
        gy  = $signed({1'b0, yt}) - $signed({1'b0, yb});
        ax  = gx[10] ? 10'(-gx) : gx[9:0];
        ay  = gy[10] ? 10'(-gy) : gy[9:0];
        ax2 = ax * ax;
        ay2 = ay * ay;
    end

    always_comb begin
        trial = r_root | (t_pix'(1) << r_bit);
        tsq   = trial * trial;
    end

    assign send_ok = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_flags.is_drain) begin
                    n_state = (r_step == 2'd2) ? ST_SUM : ST_READ;
                end else if (r_flags.emit_a || r_flags.emit_b) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_sum >= SAT_LEVEL || r_bit == 3'd0) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (send_ok) begin
                    if (!r_flags.is_drain && !r_phase && r_flags.emit_b) begin
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_flags <= i_flags;
                r_pix   <= i_pix;
                r_addr0 <= i_addr0;
                r_addr1 <= i_addr1;
                r_addr2 <= i_addr2;
                r_step  <= 2'd0;
            end
            ST_LOAD: begin
                if (r_flags.is_drain) begin
                    // drain window: upper row, then the last row twice
                    r_win[0][r_step] <= r_up_rd;
                    r_win[1][r_step] <= r_lo_rd;
                    r_win[2][r_step] <= r_lo_rd;
                    r_step  <= r_step + 2'd1;
                    r_phase <= 1'b0;
                end else begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r][0] <= r_flags.first_col ? v[r] : r_win[r][1];
                        r_win[r][1] <= r_flags.first_col ? v[r] : r_win[r][2];
                        r_win[r][2] <= v[r];
                    end
                    r_phase <= !r_flags.emit_a;
                end
            end
            ST_SUM: begin
                r_sum  <= {1'b0, ax2} + {1'b0, ay2};
                r_root <= '0;
                r_bit  <= 3'd7;
            end
            ST_ROOT: begin
                if (r_sum >= SAT_LEVEL) begin
                    r_root <= MAG_MAX;
                end else begin
                    if ({5'd0, tsq} <= r_sum) begin
                        r_root <= trial;
                    end
                    r_bit <= r_bit - 3'd1;
                end
            end
            ST_SEND: begin
                if (send_ok) begin
                    r_phase <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_SEND && send_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEND && send_ok) begin
            r_out_mag <= r_root;
            r_out_eol <= r_flags.is_drain ? r_flags.last : r_phase;
            r_out_eof <= r_flags.is_drain && r_flags.last;
            r_out_lir <= r_flags.is_drain || r_phase || !r_flags.emit_b;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_magnitude    = r_out_mag;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_frame = r_out_eof;
    assign o_last_in_run  = r_out_lir;

endmodule
